/* src/lwfs_pkg.sv */
// lwfs_pkg: shared types and constants for the window-fill byte sequencer.
// No dependencies; used by every module under src/.
`default_nettype none

package lwfs_pkg;

    // Kind codes carried on s_tuser
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_RECT  = 2'd1;
    localparam logic [1:0] FUNC_PIXEL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ORIENTATION = 2'd0;
    localparam logic [1:0] REG_VARIANT     = 2'd1;

    localparam logic [2:0] ORIENTATION_RESET = 3'd7;
    localparam logic       VARIANT_RESET     = 1'b0;

    // Controller commands
    localparam logic [7:0] CMD_RASET = 8'h2B;
    localparam logic [7:0] CMD_CASET = 8'h2A;
    localparam logic [7:0] CMD_RAMWR = 8'h2C;

    // Byte sequence steps
    localparam logic [3:0] STEP_RASET     = 4'd0;
    localparam logic [3:0] STEP_ROW_HI0   = 4'd1;
    localparam logic [3:0] STEP_ROW_FIRST = 4'd2;
    localparam logic [3:0] STEP_ROW_HI1   = 4'd3;
    localparam logic [3:0] STEP_ROW_LAST  = 4'd4;
    localparam logic [3:0] STEP_CASET     = 4'd5;
    localparam logic [3:0] STEP_COL_HI0   = 4'd6;
    localparam logic [3:0] STEP_COL_FIRST = 4'd7;
    localparam logic [3:0] STEP_COL_HI1   = 4'd8;
    localparam logic [3:0] STEP_COL_LAST  = 4'd9;
    localparam logic [3:0] STEP_RAMWR     = 4'd10;
    localparam logic [3:0] STEP_COLOR     = 4'd11;

    // Color byte select
    localparam logic [1:0] CBYTE_BLUE  = 2'd0;
    localparam logic [1:0] CBYTE_GREEN = 2'd1;
    localparam logic [1:0] CBYTE_RED   = 2'd2;

    localparam int DEFAULT_CLAMP_WIDTH  = 128;
    localparam int DEFAULT_CLAMP_HEIGHT = 128;
    localparam int QUEUE_DEPTH          = 2;

    // One classified item, front to back
    typedef struct packed {
        logic        is_req;    // 1: job setup, 0: tick
        logic        single;
        logic [7:0]  row_first;
        logic [7:0]  row_last;
        logic [7:0]  col_first;
        logic [7:0]  col_last;
        logic [23:0] color;
        logic [15:0] pixels;
    } entry_t;

endpackage

`default_nettype wire

/* src/lwfs_front.sv */
// lwfs_front: classifies incoming items and precomputes job setup
// (offsets, clamp, window ends, pixel count). Depends on lwfs_pkg.
`default_nettype none

module lwfs_front #(
    parameter int CLAMP_WIDTH  = lwfs_pkg::DEFAULT_CLAMP_WIDTH,
    parameter int CLAMP_HEIGHT = lwfs_pkg::DEFAULT_CLAMP_HEIGHT
) (
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  x_start,
    input  wire logic [7:0]  x_end,
    input  wire logic [7:0]  y_start,
    input  wire logic [7:0]  y_end,
    input  wire logic [23:0] fill_color,
    input  wire logic [2:0]  orientation,
    input  wire logic        variant,
    output logic             push_ok,     // item goes into the queue
    output lwfs_pkg::entry_t entry
);

    localparam logic [8:0] CLAMP_W9 = 9'(CLAMP_WIDTH);
    localparam logic [8:0] CLAMP_H9 = 9'(CLAMP_HEIGHT);
    localparam logic [7:0] MAX_X    = 8'(CLAMP_WIDTH - 1);
    localparam logic [7:0] MAX_Y    = 8'(CLAMP_HEIGHT - 1);

    logic        ex, mx, my, is_pixel;
    logic [7:0]  dx, dy;
    logic [7:0]  xs_in, ys_in, xe_in, ye_in;
    logic [7:0]  xs, xe, ys, ye;
    logic [15:0] diff_x, diff_y;
    logic [15:0] area;

    assign ex = orientation[0];
    assign mx = orientation[1];
    assign my = orientation[2];
    assign is_pixel = (func == lwfs_pkg::FUNC_PIXEL);

    always_comb begin
        if (!variant) begin
            if (mx && ex) begin
                dx = 8'd2; dy = 8'd3;
            end else if (my) begin
                dx = 8'd3; dy = 8'd2;
            end else if (mx) begin
                dx = 8'd1; dy = 8'd2;
            end else begin
                dx = 8'd2; dy = 8'd1;
            end
        end else begin
            dx = 8'd0; dy = 8'd0;
            if (mx && ex) begin
                dy = 8'd32;
            end else if (my) begin
                dx = 8'd32;
            end
        end
    end

    // pixel request: clamp to the panel, end equals start
    always_comb begin
        xs_in = x_start;
        ys_in = y_start;
        if (is_pixel) begin
            if ({1'b0, x_start} >= CLAMP_W9) xs_in = MAX_X;
            if ({1'b0, y_start} >= CLAMP_H9) ys_in = MAX_Y;
        end
        xe_in = is_pixel ? xs_in : x_end;
        ye_in = is_pixel ? ys_in : y_end;
    end

    assign xs = xs_in + dx;
    assign xe = xe_in + dx;
    assign ys = ys_in + dy;
    assign ye = ye_in + dy;

    // 16-bit wrapping differences, area count modulo 2^16
    assign diff_x = {8'd0, xe} - {8'd0, xs};
    assign diff_y = {8'd0, ye} - {8'd0, ys};
    assign area   = diff_x * diff_y;

    always_comb begin
        entry.is_req    = (func == lwfs_pkg::FUNC_RECT) || is_pixel;
        entry.single    = (xe == xs) && (ye == ys);
        entry.row_first = xs;
        entry.row_last  = xe - 8'd1;
        entry.col_first = ys;
        entry.col_last  = ye - 8'd1;
        entry.color     = fill_color;
        entry.pixels    = entry.single ? 16'd1 : area;
    end

    // func code 3 is dropped here
    assign push_ok = (func == lwfs_pkg::FUNC_TICK) || entry.is_req;

endmodule

`default_nettype wire

/* src/lwfs_queue.sv */
// lwfs_queue: short FIFO of classified items between front and back.
// Depends on lwfs_pkg (entry_t).
`default_nettype none

module lwfs_queue #(
    parameter int DEPTH = lwfs_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire lwfs_pkg::entry_t wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic                  rd_valid,
    output lwfs_pkg::entry_t      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lwfs_pkg::entry_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd) rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd) count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

/* src/lwfs_back.sv */
// lwfs_back: job state and byte sequencer with registered output stage.
// Consumes queued items in order. Depends on lwfs_pkg.
`default_nettype none

module lwfs_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    input  wire lwfs_pkg::entry_t q_data,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [15:0]           m_tdata,   // [7:0] out_byte, [8] release_select,
                                             // zero pad
    output logic                  m_tuser,   // [0] is_data
    output logic                  m_tlast    // last
);

    logic        busy_reg, busy_next;
    logic [3:0]  step_reg, step_next;
    logic [7:0]  row_first_reg, row_first_next, row_last_reg, row_last_next;
    logic [7:0]  col_first_reg, col_first_next, col_last_reg, col_last_next;
    logic [23:0] color_reg, color_next;
    logic [15:0] pixels_reg, pixels_next;
    logic [1:0]  cbi_reg, cbi_next;
    logic        single_reg, single_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_data_reg, out_data_next;
    logic        out_rel_reg, out_rel_next;
    logic        out_last_reg, out_last_next;

    logic        out_free, emit, fin;
    logic [7:0]  byte_v, color_byte;
    logic        data_v, rel_v;

    assign out_free = !out_valid_reg || m_tready;
    // ticks with a job pending need room in the output stage
    assign q_pop = q_valid && (q_data.is_req || !busy_reg || out_free);
    assign emit  = q_pop && !q_data.is_req && busy_reg;

    always_comb begin
        case (cbi_reg)
            lwfs_pkg::CBYTE_BLUE:  color_byte = color_reg[7:0];
            lwfs_pkg::CBYTE_GREEN: color_byte = color_reg[15:8];
            lwfs_pkg::CBYTE_RED:   color_byte = color_reg[23:16];
            default:               color_byte = 8'h00;
        endcase
    end

    always_comb begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        row_first_next = row_first_reg;
        row_last_next  = row_last_reg;
        col_first_next = col_first_reg;
        col_last_next  = col_last_reg;
        color_next     = color_reg;
        pixels_next    = pixels_reg;
        cbi_next       = cbi_reg;
        single_next    = single_reg;
        byte_v         = 8'h00;
        data_v         = 1'b1;
        rel_v          = 1'b1;
        fin            = 1'b0;

        if (q_pop && q_data.is_req && !busy_reg) begin
            busy_next      = 1'b1;
            step_next      = lwfs_pkg::STEP_RASET;
            row_first_next = q_data.row_first;
            row_last_next  = q_data.row_last;
            col_first_next = q_data.col_first;
            col_last_next  = q_data.col_last;
            color_next     = q_data.color;
            pixels_next    = q_data.pixels;
            cbi_next       = lwfs_pkg::CBYTE_BLUE;
            single_next    = q_data.single;
        end else if (emit) begin
            case (step_reg)
                lwfs_pkg::STEP_RASET: begin
                    byte_v = lwfs_pkg::CMD_RASET; data_v = 1'b0;
                end
                lwfs_pkg::STEP_ROW_HI0:   byte_v = 8'h00;
                lwfs_pkg::STEP_ROW_FIRST: byte_v = row_first_reg;
                lwfs_pkg::STEP_ROW_HI1:   byte_v = 8'h00;
                lwfs_pkg::STEP_ROW_LAST:  byte_v = row_last_reg;
                lwfs_pkg::STEP_CASET: begin
                    byte_v = lwfs_pkg::CMD_CASET; data_v = 1'b0;
                end
                lwfs_pkg::STEP_COL_HI0:   byte_v = 8'h00;
                lwfs_pkg::STEP_COL_FIRST: byte_v = col_first_reg;
                lwfs_pkg::STEP_COL_HI1:   byte_v = 8'h00;
                lwfs_pkg::STEP_COL_LAST:  byte_v = col_last_reg;
                lwfs_pkg::STEP_RAMWR: begin
                    byte_v = lwfs_pkg::CMD_RAMWR; data_v = 1'b0;
                    fin    = (pixels_reg == 16'd0);   // empty area ends here
                end
                default: begin
                    byte_v = color_byte;
                    if (cbi_reg >= lwfs_pkg::CBYTE_RED) begin
                        cbi_next    = lwfs_pkg::CBYTE_BLUE;
                        pixels_next = pixels_reg - 16'd1;
                        fin         = (pixels_next == 16'd0);
                    end else begin
                        cbi_next = cbi_reg + 2'd1;
                    end
                    rel_v = single_reg || fin;
                end
            endcase
            if (step_reg < lwfs_pkg::STEP_COLOR) step_next = step_reg + 4'd1;
            if (fin) begin
                busy_next = 1'b0;
                step_next = lwfs_pkg::STEP_RASET;
                cbi_next  = lwfs_pkg::CBYTE_BLUE;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_data_next  = out_data_reg;
        out_rel_next   = out_rel_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_v;
            out_data_next  = data_v;
            out_rel_next   = rel_v;
            out_last_next  = fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            row_first_reg <= '0;
            row_last_reg  <= '0;
            col_first_reg <= '0;
            col_last_reg  <= '0;
            color_reg     <= '0;
            pixels_reg    <= '0;
            cbi_reg       <= '0;
            single_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            row_first_reg <= row_first_next;
            row_last_reg  <= row_last_next;
            col_first_reg <= col_first_next;
            col_last_reg  <= col_last_next;
            color_reg     <= color_next;
            pixels_reg    <= pixels_next;
            cbi_reg       <= cbi_next;
            single_reg    <= single_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_data_reg <= out_data_next;
        out_rel_reg  <= out_rel_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_rel_reg, out_byte_reg};
    assign m_tuser  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* src/lcd_window_fill_sequencer.sv */
// lcd_window_fill_sequencer: top level of the window-fill byte sequencer.
// Holds the configuration registers; instantiates lwfs_front, lwfs_queue, lwfs_back.
//
// Usage:
//   s_* channel: one item per handshake. s_tuser is the kind (0 tick,
//   1 rectangle request, 2 pixel request, 3 ignored); s_tdata carries the
//   window corners and the 24-bit fill color.
//   m_* channel: one byte for the display per tick that finds a job pending.
//   m_tdata = {release_select, out_byte}, m_tuser is the data/command flag,
//   m_tlast marks the final byte of a job. Requests, idle ticks and requests
//   while busy give nothing.
//   cfg_* channel: register 0 orientation bits, register 1 panel variant.
//   Always ready; write only when no job is pending.
// Timing:
//   An item is classified in the cycle it is accepted and queued; the back
//   end takes one queued item per cycle, unless a tick for a pending job
//   finds its output register still full, so a tick's byte passes a queue
//   entry and then the output register before it shows on m_tvalid. Sustained
//   rate is one item per cycle, set by the single-step sequencer and the two-entry queue.
// Stall: with m_tready low one byte waits in the output register; further
//   items fill the queue and then s_tready drops.
// Reset (aresetn low, synchronous): job idle, queue empty, output empty,
//   orientation 7, panel variant 0.
`default_nettype none

module lcd_window_fill_sequencer #(
    parameter int CLAMP_WIDTH  = lwfs_pkg::DEFAULT_CLAMP_WIDTH,
    parameter int CLAMP_HEIGHT = lwfs_pkg::DEFAULT_CLAMP_HEIGHT,
    parameter int QUEUE_DEPTH  = lwfs_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // item input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // [7:0] x_start, [15:8] x_end, [23:16] y_start,
                                        // [31:24] y_end, [55:32] fill_color
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    // byte output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] release_select,
                                        // [15:9] zero
    output logic             m_tuser,   // [0] is_data
    output logic             m_tlast,   // last
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [2:0]       orientation_reg;
    logic             variant_reg;
    logic             push_ok, q_full, q_valid, q_pop;
    lwfs_pkg::entry_t front_entry, q_entry;

    // configuration registers; unknown indexes are ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orientation_reg <= lwfs_pkg::ORIENTATION_RESET;
            variant_reg     <= lwfs_pkg::VARIANT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                lwfs_pkg::REG_ORIENTATION: orientation_reg <= cfg_data[2:0];
                lwfs_pkg::REG_VARIANT:     variant_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // func 3 is taken and dropped, so readiness is just queue room
    assign s_tready = !q_full;

    lwfs_front #(
        .CLAMP_WIDTH  (CLAMP_WIDTH),
        .CLAMP_HEIGHT (CLAMP_HEIGHT)
    ) u_front (
        .func        (s_tuser),
        .x_start     (s_tdata[7:0]),
        .x_end       (s_tdata[15:8]),
        .y_start     (s_tdata[23:16]),
        .y_end       (s_tdata[31:24]),
        .fill_color  (s_tdata[55:32]),
        .orientation (orientation_reg),
        .variant     (variant_reg),
        .push_ok     (push_ok),
        .entry       (front_entry)
    );

    lwfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_tvalid && push_ok),
        .wr_data  (front_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_entry)
    );

    lwfs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
